// ===== src/drum_voice_synth_core_defines.svh =====
// Assertion macros shared by the drum voice checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DRUM_VOICE_SYNTH_CORE_DEFINES_SVH
`define DRUM_VOICE_SYNTH_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DVS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drum voice check failed");

// Next-cycle implication, disabled during reset
`define DVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drum voice check failed");

`endif

// ===== src/dvs_pkg.sv =====
// Types, constants, microcode program and sine table function of the drum voice.
// No dependencies; imported by drum_voice_synth_core and dvs_checker.
package dvs_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 29;

   localparam logic [CSR_IDX_W-1:0] CFG_BASE_STEP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_SWEEP_DEPTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_DECAY_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_NOISE_MIX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_AMPLITUDE    = 3'd4;

   // register reset values
   localparam logic [28:0] BASE_STEP_RST    = 29'd7158279;
   localparam logic [10:0] SWEEP_DEPTH_RST  = 11'd256;
   localparam logic [23:0] DECAY_FACTOR_RST = 24'd16768478;
   localparam logic [15:0] NOISE_MIX_RST    = 16'd19661;
   localparam logic [15:0] AMPLITUDE_RST    = 16'd32768;

   // voice state
   localparam logic [31:0] SEED_RST = 32'd12345;
   localparam logic [23:0] ENV_FULL = 24'hFFFFFF;
   localparam logic [20:0] LCG_MUL  = 21'd1664525;
   localparam logic [31:0] LCG_INC  = 32'd1013904223;

   // quarter-wave polynomial, Q30
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] SIN_C1  = 64'd1686629713;
   localparam logic [63:0] SIN_C3  = 64'd693598669;
   localparam logic [63:0] SIN_C5  = 64'd85569306;
   localparam logic [63:0] SIN_C7  = 64'd5026995;
   localparam logic [63:0] SIN_C9  = 64'd172272;

   // sequencer
   localparam int STEP_W = 4;

   typedef enum logic [0:0] {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_SEED_LCG,
      MUL_BASE_SWEEP,
      MUL_TONE_MIX,
      MUL_NOISE_MIX,
      MUL_PHI_ENV,
      MUL_PLO_ENV,
      MUL_MAG_ENV,
      MUL_ENV_DECAY,
      MUL_S_AMP
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_SEED,
      WB_P,
      WB_ACC_SET,
      WB_ACC_ADD,
      WB_TERM_HI,
      WB_TERM_LO,
      WB_S1,
      WB_ENV,
      WB_OUT
   } wb_op_type;

   // one control word: multiplier operands, writeback of last product, side ops
   typedef struct packed {
      mul_sel_type mul_sel;
      wb_op_type   wb_op;
      logic        abs_en;    // mag/sign from accumulator
      logic        phase_en;  // tone phase advance
      logic        hold_out;  // wait here while result slot is full and not being taken
      logic        last;      // jump back to start, sequencer goes idle
   } ucode_type;

   // microcode program; writeback consumes the product of the step before
   function automatic ucode_type dvs_ucode(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{mul_sel: MUL_NONE, wb_op: WB_NONE, abs_en: 1'b0, phase_en: 1'b0,
             hold_out: 1'b0, last: 1'b0};
      case (step)
         4'd0: begin
            uc.mul_sel = MUL_SEED_LCG;
         end
         4'd1: begin
            uc.mul_sel = MUL_BASE_SWEEP;
            uc.wb_op   = WB_SEED;
         end
         4'd2: begin
            uc.mul_sel = MUL_TONE_MIX;
            uc.wb_op   = WB_P;
         end
         4'd3: begin
            uc.mul_sel = MUL_NOISE_MIX;
            uc.wb_op   = WB_ACC_SET;
         end
         4'd4: begin
            uc.mul_sel = MUL_PHI_ENV;
            uc.wb_op   = WB_ACC_ADD;
         end
         4'd5: begin
            uc.mul_sel = MUL_PLO_ENV;
            uc.wb_op   = WB_TERM_HI;
            uc.abs_en  = 1'b1;
         end
         4'd6: begin
            uc.mul_sel = MUL_MAG_ENV;
            uc.wb_op   = WB_TERM_LO;
         end
         4'd7: begin
            uc.mul_sel = MUL_ENV_DECAY;
            uc.wb_op   = WB_S1;
         end
         4'd8: begin
            uc.mul_sel  = MUL_S_AMP;
            uc.wb_op    = WB_ENV;
            uc.phase_en = 1'b1;
         end
         4'd9: begin
            uc.wb_op    = WB_OUT;
            uc.hold_out = 1'b1;
            uc.last     = 1'b1;
         end
         default: begin
            uc.last = 1'b1;
         end
      endcase
      return uc;
   endfunction

   // quarter-wave sine of x (Q30 angle fraction), Q1.15; elaboration only
   function automatic logic [15:0] quarter_sine(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] y;
      x2 = (x * x) >> 30;
      t  = SIN_C9;
      t  = SIN_C7 - ((x2 * t) >> 30);
      t  = SIN_C5 - ((x2 * t) >> 30);
      t  = SIN_C3 - ((x2 * t) >> 30);
      t  = SIN_C1 - ((x2 * t) >> 30);
      y  = (x * t) >> 30;
      y  = (y + 64'd16384) >> 15;
      if (y > 64'd32767) begin
         y = 64'd32767;
      end
      return y[15:0];
   endfunction

endpackage

// ===== src/drum_voice_synth_core.sv =====
// Drum voice top level: microcoded sequencer around one shared signed multiplier.
// Depends on dvs_pkg (types, microcode program, sine table function).
//
// One req beat is one audio sample tick carrying the sequencer phase; each tick gives
// one rsp beat with the saturated Q1.15 sample and a flag in tuser that is set when
// the tick started a new hit (phase fell by more than one half). Each tick runs a
// 10-step microcode program, set by the chain of dependent products that all go
// through the single 33x25 multiplier, at most one per step. The final step waits
// only while the previous result still sits unread in the output register; a new
// beat is accepted as soon as the program ends, even with a result pending. The user
// must make configuration writes on the csr port only while no tick is in flight;
// the block does not enforce it. The quarter-wave sine table is constant logic built at elaboration.
module drum_voice_synth_core
   import dvs_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] trigger_phase
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] sample
   output logic                  rsp_tuser,   // [0] triggered
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW  = $clog2(SINE_TABLE_DEPTH);
   localparam int IPW = 31 + IW;

   // sequencer
   seq_state_type            state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   ucode_type                uc;
   logic                     req_acc;
   logic                     running;
   logic                     advance;

   // configuration registers
   logic [28:0]              base_ff, base_in;
   logic [10:0]              sweep_ff, sweep_in;
   logic [23:0]              decay_ff, decay_in;
   logic [15:0]              mix_ff, mix_in;
   logic [15:0]              amp_ff, amp_in;

   // voice state
   logic [31:0]              phase_ff, phase_in;
   logic [23:0]              env_ff, env_in;
   logic [15:0]              last_ff, last_in;
   logic [31:0]              seed_ff, seed_in;
   logic                     hit_ff, hit_in;

   // datapath
   logic signed [32:0]       mul_a;
   logic signed [24:0]       mul_b;
   logic signed [57:0]       mul_p;
   logic signed [57:0]       prod_ff, prod_in;
   logic [39:0]              p_ff, p_in;
   logic signed [33:0]       acc_ff, acc_in;
   logic [31:0]              mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [55:0]              thi_ff, thi_in;
   logic [31:0]              term_ff, term_in;
   logic [31:0]              s_ff, s_in;
   logic [16:0]              tone_share;
   logic [56:0]              term_sum;
   logic [56:0]              s1_sum;
   logic [48:0]              s2_sum;
   logic [16:0]              s2;
   logic [15:0]              smp;

   // trigger detect
   logic [16:0]              ph_diff;
   logic                     hit;

   // sine table and lookup pipeline
   logic [15:0]              sine_rom [SINE_TABLE_DEPTH];
   logic [IPW-1:0]           idx_prod;
   logic [IW-1:0]            idx;
   logic [IW:0]              mir;
   logic [IW-1:0]            rom_addr_ff, rom_addr_in;
   logic [1:0]               quad_ff, quad_in;
   logic                     idx_zero_ff, idx_zero_in;
   logic [15:0]              tone_v;
   logic signed [15:0]       tone_ff, tone_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_data_ff, rsp_data_in;
   logic                     rsp_trig_ff, rsp_trig_in;

   // constant quarter-wave table
   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] XK = (64'(k) * Q30_ONE) / 64'(SINE_TABLE_DEPTH);
      assign sine_rom[k] = quarter_sine(XK);
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (advance && uc.last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      running    = 1'b0;
      case (state_ff)
         SEQ_IDLE: req_tready = 1'b1;
         SEQ_RUN:  running    = 1'b1;
         default: begin
            req_tready = 1'b0;
            running    = 1'b0;
         end
      endcase
   end

   assign uc      = dvs_ucode(step_ff);
   assign req_acc = req_tvalid && req_tready;
   assign advance = running && !(uc.hold_out && rsp_valid_ff && !rsp_tready);

   // step counter: jump to start on the last word
   always_comb begin
      step_in = step_ff;
      if (req_acc) begin
         step_in = '0;
      end else if (advance) begin
         step_in = uc.last ? '0 : step_ff + 1'b1;
      end
   end

   // configuration writes
   always_comb begin
      base_in  = base_ff;
      sweep_in = sweep_ff;
      decay_in = decay_ff;
      mix_in   = mix_ff;
      amp_in   = amp_ff;
      if (csr_we) begin
         case (csr_index)
            CFG_BASE_STEP:    base_in  = csr_wdata[28:0];
            CFG_SWEEP_DEPTH:  sweep_in = csr_wdata[10:0];
            CFG_DECAY_FACTOR: decay_in = csr_wdata[23:0];
            CFG_NOISE_MIX:    mix_in   = csr_wdata[15:0];
            CFG_AMPLITUDE:    amp_in   = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // hit when phase drops by more than one half
   assign ph_diff = {1'b0, last_ff} - {1'b0, req_tdata};
   assign hit     = (last_ff > req_tdata) && (ph_diff > 17'd32768);

   // sine lookup, stage 1: quadrant and table address
   assign idx_prod = IPW'(phase_ff[29:0]) * IPW'(SINE_TABLE_DEPTH);
   assign idx      = idx_prod[30 +: IW];
   assign mir      = (IW+1)'(SINE_TABLE_DEPTH) - {1'b0, idx};

   always_comb begin
      quad_in     = phase_ff[31:30];
      idx_zero_in = (idx == '0);
      rom_addr_in = phase_ff[30] ? mir[IW-1:0] : idx;
   end

   // sine lookup, stage 2: mirror peak and sign
   assign tone_v  = (quad_ff[0] && idx_zero_ff) ? 16'd32767 : sine_rom[rom_addr_ff];
   assign tone_in = quad_ff[1] ? -$signed(tone_v) : $signed(tone_v);

   // shared multiplier operand select
   assign tone_share = 17'h10000 - {1'b0, mix_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_SEED_LCG: begin
            mul_a = {1'b0, seed_ff};
            mul_b = {4'b0, LCG_MUL};
         end
         MUL_BASE_SWEEP: begin
            mul_a = {4'b0, base_ff};
            mul_b = {14'b0, sweep_ff};
         end
         MUL_TONE_MIX: begin
            mul_a = {{17{tone_ff[15]}}, tone_ff};
            mul_b = {8'b0, tone_share};
         end
         MUL_NOISE_MIX: begin
            mul_a = {{17{seed_ff[31]}}, seed_ff[31:16]};
            mul_b = {9'b0, mix_ff};
         end
         MUL_PHI_ENV: begin
            mul_a = {1'b0, p_ff[39:8]};
            mul_b = {1'b0, env_ff};
         end
         MUL_PLO_ENV: begin
            mul_a = {25'b0, p_ff[7:0]};
            mul_b = {1'b0, env_ff};
         end
         MUL_MAG_ENV: begin
            mul_a = {1'b0, mag_ff};
            mul_b = {1'b0, env_ff};
         end
         MUL_ENV_DECAY: begin
            mul_a = {9'b0, env_ff};
            mul_b = {1'b0, decay_ff};
         end
         MUL_S_AMP: begin
            mul_a = {1'b0, s_ff};
            mul_b = {9'b0, amp_ff};
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // rounding and combining of finished products
   assign term_sum = {1'b0, thi_ff} + {33'b0, prod_ff[31:8]};
   assign s1_sum   = {1'b0, prod_ff[55:0]} + 57'h800000;
   assign s2_sum   = {1'b0, prod_ff[47:0]} + 49'h80000000;
   assign s2       = s2_sum[48:32];

   // saturate with restored sign
   always_comb begin
      if (neg_ff) begin
         smp = (s2 > 17'd32768) ? 16'h8000 : 16'(-s2);
      end else begin
         smp = (s2 > 17'd32767) ? 16'h7FFF : s2[15:0];
      end
   end

   // datapath writeback under microcode control
   always_comb begin
      prod_in  = prod_ff;
      seed_in  = seed_ff;
      p_in     = p_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      thi_in   = thi_ff;
      term_in  = term_ff;
      s_in     = s_ff;
      env_in   = env_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      hit_in   = hit_ff;
      if (req_acc) begin
         last_in = req_tdata;
         hit_in  = hit;
         if (hit) begin
            env_in   = ENV_FULL;
            phase_in = '0;
         end
      end
      if (advance) begin
         prod_in = mul_p;
         case (uc.wb_op)
            WB_SEED:    seed_in = prod_ff[31:0] + LCG_INC;
            WB_P:       p_in    = prod_ff[39:0];
            WB_ACC_SET: acc_in  = prod_ff[33:0];
            WB_ACC_ADD: acc_in  = acc_ff + prod_ff[33:0];
            WB_TERM_HI: thi_in  = prod_ff[55:0];
            WB_TERM_LO: term_in = term_sum[55:24];
            WB_S1:      s_in    = s1_sum[55:24];
            WB_ENV:     env_in  = prod_ff[47:24];
            default: ;
         endcase
         if (uc.abs_en) begin
            neg_in = acc_ff[33];
            mag_in = acc_ff[33] ? 32'(-acc_ff) : acc_ff[31:0];
         end
         if (uc.phase_en) begin
            phase_in = phase_ff + {3'b0, base_ff} + term_ff;
         end
      end
   end

   // result register: loads on the output step, drains on a taken beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_trig_in  = rsp_trig_ff;
      if (advance && (uc.wb_op == WB_OUT)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = smp;
         rsp_trig_in  = hit_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_trig_ff;

   // control, configuration and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_STEP_RST;
         sweep_ff     <= SWEEP_DEPTH_RST;
         decay_ff     <= DECAY_FACTOR_RST;
         mix_ff       <= NOISE_MIX_RST;
         amp_ff       <= AMPLITUDE_RST;
         phase_ff     <= '0;
         env_ff       <= '0;
         last_ff      <= '0;
         seed_ff      <= SEED_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         sweep_ff     <= sweep_in;
         decay_ff     <= decay_in;
         mix_ff       <= mix_in;
         amp_ff       <= amp_in;
         phase_ff     <= phase_in;
         env_ff       <= env_in;
         last_ff      <= last_in;
         seed_ff      <= seed_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hit_ff      <= hit_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      thi_ff      <= thi_in;
      term_ff     <= term_in;
      s_ff        <= s_in;
      rom_addr_ff <= rom_addr_in;
      quad_ff     <= quad_in;
      idx_zero_ff <= idx_zero_in;
      tone_ff     <= tone_in;
      rsp_data_ff <= rsp_data_in;
      rsp_trig_ff <= rsp_trig_in;
   end

endmodule

// ===== src/dvs_checker.sv =====
// Port-level checks of the drum voice, bound to the top level.
// Depends on dvs_pkg and drum_voice_synth_core_defines.svh.
`include "drum_voice_synth_core_defines.svh"

module dvs_checker
   import dvs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [15:0]           req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [15:0]           rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // a stalled result beat holds
   `DVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // one tick at a time: busy right after a beat is taken
   `DVS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new result only comes out of a running program
   `DVS_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind drum_voice_synth_core dvs_checker u_dvs_checker (.*);
